[design/itrt_pkg.sv]
// Shared types, constants and helpers for the integer-to-radix text converter.
package itrt_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int DIV_STEPS      = 4;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'd45;
	localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'd48;
	localparam logic [CHAR_W-1:0] ALPHA_BASE = 7'd87;
	localparam logic [CHAR_W-1:0] ERROR_CHAR = 7'd0;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

	// classification travelling from front to back with each word
	typedef struct packed {
		logic               err;
		logic               neg;
		logic [RADIX_W-1:0] radix;
	} itrt_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PRE,
		ST_MINUS,
		ST_EMIT,
		ST_ERR
	} itrt_state_t;

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < DEC_DIGITS)
			return dx + ZERO_CHAR;
		return dx + ALPHA_BASE;
	endfunction

endpackage

[design/itrt_front.sv]
// Front end: takes a word, checks the radix, and forms sign and magnitude.
module itrt_front import itrt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	input  logic                  mode,
	input  logic                  q_full,
	output logic                  busy,
	output logic                  push,
	output itrt_ctl_t             push_ctl,
	output logic [VALUE_BITS-1:0] push_mag
);

	logic neg;

	always_comb begin
		neg            = mode & value[VALUE_BITS-1];
		busy           = q_full;
		push           = start & ~q_full;
		push_ctl.err   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
		push_ctl.neg   = neg;
		push_ctl.radix = radix;
		// most negative value negates to itself, which reads right as unsigned
		push_mag       = neg ? (~value + VALUE_BITS'(1)) : value;
	end

endmodule

[design/itrt_queue.sv]
// Short queue between front and back.
module itrt_queue import itrt_pkg::*; #(
	parameter int MAG_W = VALUE_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  itrt_ctl_t        push_ctl,
	input  logic [MAG_W-1:0] push_mag,
	input  logic             pop,
	output logic             full,
	output logic             empty,
	output itrt_ctl_t        head_ctl,
	output logic [MAG_W-1:0] head_mag
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	itrt_ctl_t        ctl_mem [QUEUE_DEPTH];
	logic [MAG_W-1:0] mag_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign head_ctl = ctl_mem[rd_ptr_q];
	assign head_mag = mag_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_mem[wr_ptr_q] <= push_ctl;
			mag_mem[wr_ptr_q] <= push_mag;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue read while empty");
`endif

endmodule

[design/itrt_back.sv]
// Back end: digit division, digit store and character emission.
module itrt_back import itrt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  itrt_ctl_t             head_ctl,
	input  logic [VALUE_BITS-1:0] head_mag,
	output logic                  pop,
	output logic                  strobe,
	output logic [CHAR_W-1:0]     text_char,
	output logic                  last,
	output logic                  error
);

	localparam int STORE_DEPTH = VALUE_BITS + 1;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int DIV_CYC     = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int PAD_W       = DIV_CYC * DIV_STEPS;
	localparam int DC_W        = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

	itrt_state_t state_q, state_d;

	logic [CHAR_W-1:0]  store_mem [STORE_DEPTH];
	logic [CHAR_W-1:0]  rd_data_q;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   idx_q;
	logic [DC_W-1:0]    div_cnt_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] radix_q;
	logic [PAD_W-1:0]   quo_q;
	logic               neg_q;

	logic [RADIX_W-1:0]   rem_next;
	logic [DIV_STEPS-1:0] qbits;
	logic [PAD_W-1:0]     quo_next;
	logic                 div_last;
	logic                 load;
	logic                 digit_wr;

	// DIV_STEPS restoring-division steps per cycle on the narrow remainder
	always_comb begin
		logic [RADIX_W:0] t;
		rem_next = rem_q;
		qbits    = '0;
		t        = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			t = {rem_next, quo_q[PAD_W-1-i]};
			if (t >= {1'b0, radix_q}) begin
				t = t - {1'b0, radix_q};
				qbits[DIV_STEPS-1-i] = 1'b1;
			end
			rem_next = t[RADIX_W-1:0];
		end
		quo_next = {quo_q[PAD_W-DIV_STEPS-1:0], qbits};
	end

	assign div_last = (div_cnt_q == DC_W'(DIV_CYC - 1));

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		digit_wr  = 1'b0;
		strobe    = 1'b0;
		text_char = ERROR_CHAR;
		last      = 1'b0;
		error     = 1'b0;
		rd_addr   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (head_ctl.err) begin
						state_d = ST_ERR;
					end else begin
						load    = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_last) begin
					digit_wr = 1'b1;
					if (quo_next == '0)
						state_d = ST_PRE;
				end
			end
			ST_PRE: begin
				state_d = neg_q ? ST_MINUS : ST_EMIT;
			end
			ST_MINUS: begin
				strobe    = 1'b1;
				text_char = MINUS_CHAR;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				strobe    = 1'b1;
				text_char = rd_data_q;
				last      = (idx_q == '0);
				if (idx_q != '0)
					rd_addr = idx_q - IDX_W'(1);
				if (idx_q == '0)
					state_d = ST_IDLE;
			end
			ST_ERR: begin
				strobe    = 1'b1;
				text_char = ERROR_CHAR;
				last      = 1'b1;
				error     = 1'b1;
				state_d   = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				idx_q     <= '0;
				div_cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				div_cnt_q <= div_last ? '0 : div_cnt_q + DC_W'(1);
				if (digit_wr && quo_next != '0)
					idx_q <= idx_q + IDX_W'(1);
			end else if (state_q == ST_EMIT && idx_q != '0) begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q   <= PAD_W'(head_mag);
			radix_q <= head_ctl.radix;
			neg_q   <= head_ctl.neg;
			rem_q   <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q <= quo_next;
			rem_q <= div_last ? '0 : rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (digit_wr)
			store_mem[idx_q] <= digit_to_char(rem_next);
		rd_data_q <= store_mem[rd_addr];
	end

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> (state_q == ST_IDLE)) else $error("word after last");
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && error) |-> last) else $error("error word not last");
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MINUS) |=> (state_q == ST_EMIT && strobe))
		else $error("sign not followed by digits");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !error) |-> (idx_q < IDX_W'(VALUE_BITS))) else $error("digit index range");
`endif

endmodule

[design/integer_to_radix_text.sv]
// Converts one integer to ASCII text in radix 2..36, most significant digit first.
// A word is taken when start is high and busy is low; busy rises only while the
// two-entry input queue is full. The back end divides the magnitude by the radix
// four quotient bits per cycle, giving one digit per division; after the last
// digit a separate state reads the digit store, then one character leaves per
// cycle, a leading '-' first for a negative signed value. At 32 bits the worst
// case is radix 2, with 32 digits and 33 characters. A bad radix gives one word
// with error and last set, in the cycle after it reaches the back end.
// Results appear for one cycle with strobe and cannot be held off: the receiver
// must take every strobed word.
module integer_to_radix_text import itrt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    radix,
	input  logic                  mode,
	output logic                  strobe,
	output logic [CHAR_W-1:0]     text_char,
	output logic                  last,
	output logic                  error
);

	logic                  push;
	logic                  pop;
	logic                  q_full;
	logic                  q_empty;
	itrt_ctl_t             push_ctl;
	itrt_ctl_t             head_ctl;
	logic [VALUE_BITS-1:0] push_mag;
	logic [VALUE_BITS-1:0] head_mag;

	itrt_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.start    (start),
		.value    (value),
		.radix    (radix),
		.mode     (mode),
		.q_full   (q_full),
		.busy     (busy),
		.push     (push),
		.push_ctl (push_ctl),
		.push_mag (push_mag)
	);

	itrt_queue #(.MAG_W(VALUE_BITS)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ctl (push_ctl),
		.push_mag (push_mag),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head_ctl (head_ctl),
		.head_mag (head_mag)
	);

	itrt_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head_ctl  (head_ctl),
		.head_mag  (head_mag),
		.pop       (pop),
		.strobe    (strobe),
		.text_char (text_char),
		.last      (last),
		.error     (error)
	);

endmodule
